>>> rtl/core/mmfs_pkg.sv
`default_nettype none

package mmfs_pkg;

  // Field and storage sizes
  localparam int unsigned MAX_COLUMNS = 16;
  localparam int unsigned COL_W       = 4;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned FIT_W       = 2;

  // Stream widths: tdata packed from the lowest bit, padded to whole bytes
  localparam int unsigned S_TDATA_RAW = COL_W + 2 * DATA_W;
  localparam int unsigned S_TDATA_W   = ((S_TDATA_RAW + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W   = 3 * DATA_W;

  // Divider sizes: difference of two signed words, then shifted fraction
  localparam int unsigned DIFF_W    = DATA_W + 1;
  localparam int unsigned DVD_W     = DIFF_W + FRAC_BITS;
  localparam int unsigned DIV_CNT_W = $clog2(DVD_W);

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(MAX_COLUMNS);
  localparam logic [FIT_W-1:0]   FIT_NONE    = 2'd0;
  localparam logic [FIT_W-1:0]   FIT_ONE     = 2'd1;
  localparam logic [FIT_W-1:0]   FIT_READY   = 2'd2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR     = 2'd0,
    OP_FIT       = 2'd1,
    OP_TRANSFORM = 2'd2,
    OP_LOAD      = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_COL   = 2'd1,
    STATUS_NOT_READY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] col_max;
    logic signed [DATA_W-1:0] col_min;
    logic signed [DATA_W-1:0] scaled;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/core/mmfs_divider.sv
`default_nettype none

module mmfs_divider (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  input  wire logic signed [mmfs_pkg::DIFF_W-1:0]   num_i,
  input  wire logic signed [mmfs_pkg::DIFF_W-1:0]   den_i,
  output logic                                      done_o,
  output logic signed [mmfs_pkg::DATA_W-1:0]        quot_o
);

  localparam int unsigned DVD_W  = mmfs_pkg::DVD_W;
  localparam int unsigned DIFF_W = mmfs_pkg::DIFF_W;
  localparam int unsigned DATA_W = mmfs_pkg::DATA_W;

  logic [DVD_W-1:0]               dvd_q, dvd_d;
  logic [DIFF_W-1:0]              rem_q, rem_d;
  logic [DIFF_W-1:0]              dsr_q, dsr_d;
  logic [mmfs_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic                           neg_q, neg_d;

  logic [DIFF_W-1:0] mag_n, mag_d;
  logic [DIFF_W:0]   rem_sh, diff;
  logic              over_pos, over_neg;

  // Magnitudes and sign of the quotient
  assign mag_n = num_i[DIFF_W-1] ? DIFF_W'(-num_i) : DIFF_W'(num_i);
  assign mag_d = den_i[DIFF_W-1] ? DIFF_W'(-den_i) : DIFF_W'(den_i);

  // One restoring step: shift in the next dividend bit, try to subtract
  assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dsr_q};

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d  = {mag_n, {mmfs_pkg::FRAC_BITS{1'b0}}};
      rem_d  = '0;
      dsr_d  = mag_d;
      cnt_d  = mmfs_pkg::DIV_CNT_W'(DVD_W - 1);
      busy_d = 1'b1;
      neg_d  = num_i[DIFF_W-1] ^ den_i[DIFF_W-1];
    end else if (busy_q) begin
      if (!diff[DIFF_W]) begin
        rem_d = diff[DIFF_W-1:0];
        dvd_d = {dvd_q[DVD_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DIFF_W-1:0];
        dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    neg_q <= neg_d;
  end

  // Saturate the quotient magnitude to the signed word range
  assign over_pos = |dvd_q[DVD_W-1:DATA_W-1];
  assign over_neg = (|dvd_q[DVD_W-1:DATA_W]) |
                    (dvd_q[DATA_W-1] & (|dvd_q[DATA_W-2:0]));

  always_comb begin
    if (neg_q) begin
      if (over_neg) quot_o = {1'b1, {(DATA_W-1){1'b0}}};
      else          quot_o = DATA_W'(-dvd_q[DATA_W-1:0]);
    end else begin
      if (over_pos) quot_o = {1'b0, {(DATA_W-1){1'b1}}};
      else          quot_o = dvd_q[DATA_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

>>> rtl/core/min_max_feature_scaler.sv
`default_nettype none

// Per-column min-max normalizer on signed Q16.16 samples.
// Input beats arrive on the s_axis channel: tuser carries the operation
// (clear, fit, transform, load) and tdata the column, the value and the
// upper value. Each input beat yields exactly one output beat on m_axis:
// tuser carries the status, tdata the normalized value and the column's
// stored minimum and maximum. The user must write the column_count register
// only while the block is idle (cfg_we_i / cfg_wdata_i); it is not enforced.
// Clear, fit, load, error and equal-bound transform beats go from the
// decode state through the result register into the output register.
// A transform that divides waits in between for the shared radix-2
// restoring divider, which retires one quotient bit per cycle over 49
// bits. s_axis_tready is high only between items, so the block works on
// one item at a time.
// Reset clears column_count to 16, the fit counts of all columns and the
// output valid; stored minimum and maximum are left as they are.
// A finished result waits in the output register; the next item is taken
// meanwhile, and its result is held back until the receiver takes the
// previous beat.

module min_max_feature_scaler (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // Configuration: column_count
  input  wire logic                               cfg_we_i,
  input  wire logic [mmfs_pkg::COUNT_W-1:0]       cfg_wdata_i,
  // Input stream
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // tdata: column[3:0], value[35:4], upper_value[67:36], zero pad
  input  wire logic [mmfs_pkg::S_TDATA_W-1:0]     s_axis_tdata,
  // tuser: operation[1:0]
  input  wire logic [mmfs_pkg::OP_W-1:0]          s_axis_tuser,
  // Output stream
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  // tdata: norm_value[31:0], column_min[63:32], column_max[95:64]
  output logic [mmfs_pkg::M_TDATA_W-1:0]          m_axis_tdata,
  // tuser: status[1:0]
  output logic [mmfs_pkg::STATUS_W-1:0]           m_axis_tuser
);

  localparam int unsigned DATA_W = mmfs_pkg::DATA_W;
  localparam int unsigned COL_W  = mmfs_pkg::COL_W;
  localparam int unsigned DIFF_W = mmfs_pkg::DIFF_W;

  mmfs_pkg::state_e  state_q, state_d;
  mmfs_pkg::result_t res_q, res_d;
  mmfs_pkg::result_t out_q;
  logic              out_valid_q;
  logic              out_load;

  logic [mmfs_pkg::COUNT_W-1:0] column_count_q;

  logic [mmfs_pkg::OP_W-1:0]   op_q;
  logic [COL_W-1:0]            col_q;
  logic signed [DATA_W-1:0]    val_q, up_q;

  logic signed [DATA_W-1:0]    min_q [mmfs_pkg::MAX_COLUMNS];
  logic signed [DATA_W-1:0]    max_q [mmfs_pkg::MAX_COLUMNS];
  logic [mmfs_pkg::FIT_W-1:0]  fit_q [mmfs_pkg::MAX_COLUMNS];

  logic                        in_acc;
  logic                        bound_we, fit_we, fit_clr;
  logic signed [DATA_W-1:0]    bound_min, bound_max;
  logic [mmfs_pkg::FIT_W-1:0]  fit_new;

  logic signed [DATA_W-1:0]    cur_min, cur_max;
  logic [mmfs_pkg::FIT_W-1:0]  cur_fit;
  logic signed [DIFF_W-1:0]    num, den;
  logic                        div_start, div_done;
  logic signed [DATA_W-1:0]    div_quot;

  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign s_axis_tready = (state_q == mmfs_pkg::ST_IDLE);

  assign cur_min = min_q[col_q];
  assign cur_max = max_q[col_q];
  assign cur_fit = fit_q[col_q];
  assign num     = DIFF_W'(val_q) - DIFF_W'(cur_min);
  assign den     = DIFF_W'(cur_max) - DIFF_W'(cur_min);

  // Sequence one item: decode, update statistics, divide, deliver
  always_comb begin
    state_d   = state_q;
    res_d     = res_q;
    bound_we  = 1'b0;
    bound_min = val_q;
    bound_max = up_q;
    fit_we    = 1'b0;
    fit_new   = mmfs_pkg::FIT_READY;
    fit_clr   = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      mmfs_pkg::ST_IDLE: begin
        if (in_acc) state_d = mmfs_pkg::ST_EXEC;
      end
      mmfs_pkg::ST_EXEC: begin
        res_d   = '0;
        state_d = mmfs_pkg::ST_DONE;
        if (op_q == mmfs_pkg::OP_CLEAR) begin
          fit_clr = 1'b1;
        end else if ({1'b0, col_q} >= column_count_q) begin
          res_d.status = mmfs_pkg::STATUS_BAD_COL;
        end else begin
          case (op_q)
            mmfs_pkg::OP_FIT: begin
              bound_we = 1'b1;
              fit_we   = 1'b1;
              if (cur_fit == mmfs_pkg::FIT_NONE) begin
                bound_min = val_q;
                bound_max = val_q;
                fit_new   = mmfs_pkg::FIT_ONE;
              end else begin
                bound_min = (val_q < cur_min) ? val_q : cur_min;
                bound_max = (val_q > cur_max) ? val_q : cur_max;
                fit_new   = mmfs_pkg::FIT_READY;
              end
              res_d.col_min = bound_min;
              res_d.col_max = bound_max;
            end
            mmfs_pkg::OP_TRANSFORM: begin
              if (cur_fit != mmfs_pkg::FIT_NONE) begin
                res_d.col_min = cur_min;
                res_d.col_max = cur_max;
              end
              if (cur_fit != mmfs_pkg::FIT_READY) begin
                res_d.status = mmfs_pkg::STATUS_NOT_READY;
              end else if (den == '0) begin
                res_d.scaled = val_q;
              end else begin
                div_start = 1'b1;
                state_d   = mmfs_pkg::ST_DIV;
              end
            end
            default: begin
              bound_we      = 1'b1;
              fit_we        = 1'b1;
              fit_new       = mmfs_pkg::FIT_READY;
              res_d.col_min = val_q;
              res_d.col_max = up_q;
            end
          endcase
        end
      end
      mmfs_pkg::ST_DIV: begin
        if (div_done) begin
          res_d.scaled = div_quot;
          state_d      = mmfs_pkg::ST_DONE;
        end
      end
      mmfs_pkg::ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = mmfs_pkg::ST_IDLE;
        end
      end
      default: state_d = mmfs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mmfs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the configured column count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= mmfs_pkg::COUNT_RESET;
    end else if (cfg_we_i) begin
      column_count_q <= cfg_wdata_i;
    end
  end

  // Capture the accepted beat
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q  <= s_axis_tuser;
      col_q <= s_axis_tdata[COL_W-1:0];
      val_q <= s_axis_tdata[COL_W +: DATA_W];
      up_q  <= s_axis_tdata[COL_W+DATA_W +: DATA_W];
    end
    res_q <= res_d;
  end

  // Column statistics; fit counts reset, bounds only written
  always_ff @(posedge clk_i) begin
    if (bound_we) begin
      min_q[col_q] <= bound_min;
      max_q[col_q] <= bound_max;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < mmfs_pkg::MAX_COLUMNS; i++) fit_q[i] <= mmfs_pkg::FIT_NONE;
    end else if (fit_clr) begin
      for (int i = 0; i < mmfs_pkg::MAX_COLUMNS; i++) fit_q[i] <= mmfs_pkg::FIT_NONE;
    end else if (fit_we) begin
      fit_q[col_q] <= fit_new;
    end
  end

  mmfs_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Output register: load a finished result, drop valid when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= res_q;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.status;
  assign m_axis_tdata  = {out_q.col_max, out_q.col_min, out_q.scaled};

endmodule

`default_nettype wire

>>> tb/sv/min_max_feature_scaler_tb.sv
`timescale 1ns / 100ps

module min_max_feature_scaler_tb;
  import mmfs_pkg::*;

  // Column counts for the random phases, extremes included
  localparam logic [COUNT_W-1:0] COUNT_PLAN [6] = '{5'd16, 5'd1, 5'd9, 5'd16, 5'd2, 5'd13};
  localparam int unsigned ITEMS_PER_PHASE = 83;
  localparam int unsigned DRAIN_CYCLES    = 100;

  // Running min/max predictor plus queue of expected output beats
  class minmax_scoreboard;
    logic signed [DATA_W-1:0] col_lo [MAX_COLUMNS];
    logic signed [DATA_W-1:0] col_hi [MAX_COLUMNS];
    logic [FIT_W-1:0]         rows_seen [MAX_COLUMNS];
    logic [COUNT_W-1:0]       active_cols;
    result_t                  expected_q [$];
    int unsigned              mismatches;

    function new();
      for (int i = 0; i < MAX_COLUMNS; i++) begin
        col_lo[i]    = '0;
        col_hi[i]    = '0;
        rows_seen[i] = FIT_NONE;
      end
      active_cols = COUNT_RESET;
      mismatches  = 0;
    endfunction

    // (v - lo) * 2^FRAC_BITS / (hi - lo), truncated toward zero, saturated
    function logic [DATA_W-1:0] normalize(longint v, longint lo, longint hi);
      longint      num;
      longint      den;
      logic [63:0] mag_n;
      logic [63:0] mag_d;
      logic [63:0] quo;
      bit          neg;
      num = v - lo;
      den = hi - lo;
      if (den == 0) return DATA_W'(v);
      neg   = (num < 0) != (den < 0);
      mag_n = (num < 0) ? -num : num;
      mag_d = (den < 0) ? -den : den;
      quo   = (mag_n << FRAC_BITS) / mag_d;
      if (neg) begin
        if (quo > 64'h8000_0000) quo = 64'h8000_0000;
        return DATA_W'(64'd0 - quo);
      end
      if (quo > 64'h7FFF_FFFF) quo = 64'h7FFF_FFFF;
      return DATA_W'(quo);
    endfunction

    // Fold one accepted input beat into the column state, queue its result
    function void accept_item(op_e op, logic [COL_W-1:0] col,
                              logic signed [DATA_W-1:0] value,
                              logic signed [DATA_W-1:0] upper);
      result_t     res;
      int unsigned limit;
      res   = '0;
      limit = (active_cols < MAX_COLUMNS) ? active_cols : MAX_COLUMNS;
      if (op == OP_CLEAR) begin
        for (int i = 0; i < MAX_COLUMNS; i++) rows_seen[i] = FIT_NONE;
      end else if (col >= limit) begin
        res.status = STATUS_BAD_COL;
      end else begin
        case (op)
          OP_FIT: begin
            if (rows_seen[col] == FIT_NONE) begin
              col_lo[col]    = value;
              col_hi[col]    = value;
              rows_seen[col] = FIT_ONE;
            end else begin
              if (value < col_lo[col]) col_lo[col] = value;
              if (value > col_hi[col]) col_hi[col] = value;
              rows_seen[col] = FIT_READY;
            end
          end
          OP_TRANSFORM: begin
            if (rows_seen[col] != FIT_READY) res.status = STATUS_NOT_READY;
            else res.scaled = normalize(value, col_lo[col], col_hi[col]);
          end
          default: begin
            col_lo[col]    = value;
            col_hi[col]    = upper;
            rows_seen[col] = FIT_READY;
          end
        endcase
        // Empty columns read back as zero
        if (rows_seen[col] != FIT_NONE) begin
          res.col_min = col_lo[col];
          res.col_max = col_hi[col];
        end
      end
      expected_q.push_back(res);
    endfunction

    // Compare one output beat with the oldest expectation
    function void check_beat(logic [STATUS_W-1:0] status, logic [DATA_W-1:0] scaled,
                             logic [DATA_W-1:0] cmin, logic [DATA_W-1:0] cmax);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("output beat with no result expected (status %0d)", status);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      if (status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, status);
        mismatches++;
      end
      if (scaled !== want.scaled) begin
        $error("norm_value: expected 0x%08h, actual 0x%08h", want.scaled, scaled);
        mismatches++;
      end
      if (cmin !== want.col_min) begin
        $error("column_min: expected 0x%08h, actual 0x%08h", want.col_min, cmin);
        mismatches++;
      end
      if (cmax !== want.col_max) begin
        $error("column_max: expected 0x%08h, actual 0x%08h", want.col_max, cmax);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [COUNT_W-1:0]     cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata;
  logic [OP_W-1:0]        s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [M_TDATA_W-1:0]   m_axis_tdata;
  logic [STATUS_W-1:0]    m_axis_tuser;

  minmax_scoreboard board;
  int unsigned      send_idle_pct;
  int unsigned      recv_idle_pct;
  int unsigned      items_sent;

  min_max_feature_scaler u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver backpressure, toggled at the falling edge
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= (recv_idle_pct == 0) || ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every output beat taken
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      board.check_beat(m_axis_tuser, m_axis_tdata[31:0], m_axis_tdata[63:32],
                       m_axis_tdata[95:64]);
    end
  end

  // Drive one input beat, with random idle cycles ahead of it
  task automatic send_item(op_e op, logic [COL_W-1:0] col,
                           logic [DATA_W-1:0] value, logic [DATA_W-1:0] upper);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(S_TDATA_W - S_TDATA_RAW){1'b0}}, upper, value, col};
    do @(posedge clk_i); while (!s_axis_tready);
    board.accept_item(op, col, value, upper);
    items_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // Hold until every expected result has come back
  task automatic wait_results();
    while (board.expected_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_column_count(logic [COUNT_W-1:0] count);
    stop_sending();
    wait_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= count;
    board.active_cols = count;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly in-range columns, sometimes any column
  function automatic logic [COL_W-1:0] pick_column();
    if ($urandom_range(9) == 0) return COL_W'($urandom_range(15));
    return COL_W'($urandom_range(board.active_cols - 1));
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2, 3: return $urandom();
      4, 5, 6:    return $urandom_range(32'h0020_0000) - 32'h0010_0000;
      7: begin
        case ($urandom_range(5))
          0:       return 32'h8000_0000;
          1:       return 32'h7FFF_FFFF;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          4:       return 32'h0000_0001;
          default: return 32'h0001_0000;
        endcase
      end
      default:    return $urandom_range(32'h0003_0000);
    endcase
  endfunction

  // One random sequence: fit then transform, load then transform, or noise
  task automatic random_burst();
    logic [COL_W-1:0]  col;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    int unsigned       reps;
    col = pick_column();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: begin
        reps = $urandom_range(1, 4);
        repeat (reps) send_item(OP_FIT, col, pick_value(), $urandom());
        reps = $urandom_range(1, 3);
        repeat (reps) send_item(OP_TRANSFORM, col, pick_value(), $urandom());
      end
      5, 6: begin
        lo = pick_value();
        hi = ($urandom_range(5) == 0) ? lo : pick_value();
        send_item(OP_LOAD, col, lo, hi);
        reps = $urandom_range(1, 3);
        repeat (reps) send_item(OP_TRANSFORM, col, pick_value(), $urandom());
      end
      7, 8: begin
        send_item(op_e'($urandom_range(1, 3)), COL_W'($urandom_range(15)), pick_value(),
                  $urandom());
      end
      default: begin
        if ($urandom_range(2) == 0) begin
          send_item(OP_CLEAR, COL_W'($urandom_range(15)), $urandom(), $urandom());
        end else begin
          send_item(OP_TRANSFORM, col, pick_value(), pick_value());
        end
      end
    endcase
  endtask

  initial begin
    int unsigned target;
    int unsigned pause_at;
    bit          paused;
    board         = new();
    send_idle_pct = 30;
    recv_idle_pct = 49;
    items_sent    = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty and single-row columns, field extremes
    send_item(OP_TRANSFORM, 4'd0, 32'h0001_0000, $urandom());
    send_item(OP_FIT, 4'd0, 32'h8000_0000, $urandom());
    send_item(OP_TRANSFORM, 4'd0, 32'h0000_0000, $urandom());
    send_item(OP_FIT, 4'd0, 32'h7FFF_FFFF, $urandom());
    send_item(OP_TRANSFORM, 4'd0, 32'h7FFF_FFFF, $urandom());
    send_item(OP_TRANSFORM, 4'd0, 32'h8000_0000, $urandom());
    send_item(OP_TRANSFORM, 4'd0, 32'h0000_0000, $urandom());
    // Equal bounds pass the value through
    send_item(OP_FIT, 4'd15, 32'h0005_0000, $urandom());
    send_item(OP_FIT, 4'd15, 32'h0005_0000, $urandom());
    send_item(OP_TRANSFORM, 4'd15, 32'hFEDC_BA98, $urandom());
    // Narrow loaded range saturates both ways
    send_item(OP_LOAD, 4'd7, 32'h0000_0000, 32'h0000_0001);
    send_item(OP_TRANSFORM, 4'd7, 32'h7FFF_FFFF, $urandom());
    send_item(OP_TRANSFORM, 4'd7, 32'h8000_0000, $urandom());
    // Loaded max below min gives a negative divisor
    send_item(OP_LOAD, 4'd9, 32'h0001_0000, 32'hFFFF_0000);
    send_item(OP_TRANSFORM, 4'd9, 32'h0000_0000, $urandom());
    send_item(OP_TRANSFORM, 4'd9, 32'h0003_0000, $urandom());
    // Clear forgets everything
    send_item(OP_CLEAR, 4'd5, $urandom(), $urandom());
    send_item(OP_TRANSFORM, 4'd0, 32'h0000_1234, $urandom());
    send_item(OP_FIT, 4'd0, 32'hFFFF_8000, $urandom());
    // Columns beyond the configured count
    write_column_count(5'd4);
    send_item(OP_FIT, 4'd4, 32'h0002_0000, $urandom());
    send_item(OP_TRANSFORM, 4'd15, 32'h0002_0000, $urandom());
    send_item(OP_LOAD, 4'd3, 32'h8000_0000, 32'h7FFF_FFFF);
    send_item(OP_TRANSFORM, 4'd3, 32'hFFFF_FFFF, $urandom());

    // Random phases: receiver idles more, then sender idles more, then neither
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 2) begin
        send_idle_pct = 49;
        recv_idle_pct = 30;
      end else if (phase == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_column_count(COUNT_PLAN[phase]);
      target   = items_sent + ITEMS_PER_PHASE;
      pause_at = items_sent + $urandom_range(10, ITEMS_PER_PHASE - 10);
      paused   = 1'b0;
      while (items_sent < target) begin
        // Let the pipeline run dry once per phase
        if (!paused && items_sent >= pause_at) begin
          stop_sending();
          wait_results();
          paused = 1'b1;
        end
        random_burst();
      end
    end

    stop_sending();
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.mismatches == 0 && board.expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
